/* rtl/mbfp_pkg.sv */
// Package for the MSB-first bit field packer.
// Request and result types, config register indexes and request kinds.
// No dependencies.
package mbfp_pkg;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_PAD    = 1'b1;

    localparam logic REG_LIMIT_ENABLE = 1'b0;
    localparam logic REG_BUFFER_BYTES = 1'b1;

    localparam int CFG_DATA_W = 32;
    localparam logic [31:0] BUFFER_BYTES_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        kind;
        logic [63:0] field_value;
        logic [6:0]  bit_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [31:0] byte_offset;
        logic        stored;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        limit_enable;
        logic [31:0] buffer_bytes;
    } cfg_t;

endpackage

/* rtl/mbfp_front.sv */
// Front end: accepts requests, clamps bit counts, resolves padding to a bit count.
// Tracks the partial byte fill on its own. Uses mbfp_pkg.
module mbfp_front #(
    parameter int MAX_FIELD_BITS = 64,
    parameter int CW             = $clog2(MAX_FIELD_BITS + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  mbfp_pkg::in_item_t             s_data,
    output logic                           q_push,
    input  logic                           q_full,
    output logic [CW+MAX_FIELD_BITS-1:0]   q_wdata
);

    logic [2:0]                  fill_reg;
    logic [2:0]                  fill_next;
    logic [2:0]                  pad_count;
    logic [6:0]                  eff_count;
    logic [CW-1:0]               n_bits;
    logic [CW-1:0]               shamt;
    logic [MAX_FIELD_BITS-1:0]   aligned;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        eff_count = (s_data.bit_count > 7'(MAX_FIELD_BITS)) ? 7'(MAX_FIELD_BITS)
                                                             : s_data.bit_count;
        shamt     = CW'(MAX_FIELD_BITS) - CW'(eff_count);
        aligned   = s_data.field_value[MAX_FIELD_BITS-1:0] << shamt;
        pad_count = 3'd0 - fill_reg;
        if (s_data.kind == mbfp_pkg::KIND_PAD) begin
            n_bits    = CW'(pad_count);
            fill_next = 3'd0;
            q_wdata   = {n_bits, {MAX_FIELD_BITS{1'b0}}};
        end else begin
            n_bits    = CW'(eff_count);
            fill_next = fill_reg + eff_count[2:0];
            q_wdata   = {n_bits, aligned};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 3'd0;
        end else if (q_push) begin
            fill_reg <= fill_next;
        end
    end

endmodule

/* rtl/mbfp_queue.sv */
// Two-entry FIFO between front and back end.
// No dependencies.
module mbfp_queue #(
    parameter int WIDTH = 71
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/mbfp_back.sv */
// Back end: shifts queued bits into the partial byte, one chunk per cycle while the
// result register is free or taken, and drives the result register. Uses mbfp_pkg.
module mbfp_back #(
    parameter int MAX_FIELD_BITS = 64,
    parameter int CW             = $clog2(MAX_FIELD_BITS + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mbfp_pkg::cfg_t                 cfg,
    input  logic                           q_empty,
    input  logic [CW+MAX_FIELD_BITS-1:0]   q_rdata,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output mbfp_pkg::out_item_t            m_data
);

    logic [MAX_FIELD_BITS-1:0] work_reg;
    logic [MAX_FIELD_BITS-1:0] work_next;
    logic [CW-1:0]             wcnt_reg;
    logic [CW-1:0]             wcnt_next;
    logic [7:0]                pbits_reg;
    logic [7:0]                pbits_next;
    logic [2:0]                pcount_reg;
    logic [2:0]                pcount_next;
    logic [31:0]               pos_reg;
    logic [31:0]               pos_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    mbfp_pkg::out_item_t       m_data_reg;
    mbfp_pkg::out_item_t       m_data_next;

    logic        out_free;
    logic        step;
    logic        emit;
    logic        keep;
    logic [3:0]  avail;
    logic [3:0]  k;
    logic [15:0] pshift;
    logic [7:0]  chunk;
    logic [7:0]  merged;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        step     = (wcnt_reg != '0) && out_free;
        q_pop    = (wcnt_reg == '0) && !q_empty;

        avail  = 4'd8 - {1'b0, pcount_reg};
        k      = (wcnt_reg < CW'(avail)) ? 4'(wcnt_reg) : avail;
        pshift = {8'h00, pbits_reg} << k;
        chunk  = work_reg[MAX_FIELD_BITS-1 -: 8] >> (4'd8 - k);
        merged = pshift[7:0] | chunk;
        emit   = ({1'b0, pcount_reg} + k) == 4'd8;
        keep   = !(cfg.limit_enable && (pos_reg >= cfg.buffer_bytes));

        work_next    = work_reg;
        wcnt_next    = wcnt_reg;
        pbits_next   = pbits_reg;
        pcount_next  = pcount_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (q_pop) begin
            wcnt_next = q_rdata[CW+MAX_FIELD_BITS-1 -: CW];
            work_next = q_rdata[MAX_FIELD_BITS-1:0];
        end else if (step) begin
            work_next = work_reg << k;
            wcnt_next = wcnt_reg - CW'(k);
            if (emit) begin
                pbits_next              = 8'h00;
                pcount_next             = 3'd0;
                m_valid_next            = 1'b1;
                m_data_next.out_byte    = merged;
                m_data_next.byte_offset = pos_reg;
                m_data_next.stored      = keep;
                // fewer than 8 bits left: no further byte from this request
                m_data_next.last        = (wcnt_reg - CW'(k)) < CW'(8);
                if (keep) begin
                    pos_next = pos_reg + 32'd1;
                end
            end else begin
                pbits_next  = merged;
                pcount_next = pcount_reg + k[2:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        work_reg   <= work_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcnt_reg    <= '0;
            pbits_reg   <= 8'h00;
            pcount_reg  <= 3'd0;
            pos_reg     <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            wcnt_reg    <= wcnt_next;
            pbits_reg   <= pbits_next;
            pcount_reg  <= pcount_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* rtl/msb_first_bit_field_packer.sv */
// MSB-first bit field packer, top level.
// Instantiates mbfp_front, mbfp_queue and mbfp_back; uses mbfp_pkg.
//
// Usage:
//   s_* channel (valid/ready): one request appends the low bit_count bits of
//   field_value, MSB first (counts above MAX_FIELD_BITS are clamped), or pads
//   zeros to the next byte boundary.
//   m_* channel (valid/ready): one result per completed byte, with its byte
//   offset, stored flag (0 when dropped by the capacity limit) and last on the
//   final byte caused by a request. Zero-bit appends and pads when aligned
//   give no result.
//   cfg_*: index 0 = limit_enable, 1 = buffer_bytes; write only while idle.
// Path: with an idle back end, a byte completed by the first chunk of a request
//   goes through the queue and the work register into the result register.
// Flow: the back end loads a request from the queue, then shifts it in chunks,
//   one per completed byte plus one for bits left in the partial byte; it loads
//   the next request only when the last is through. The front end runs ahead
//   through a two-entry queue.
// Reset (aresetn low, synchronous): partial byte, position and queue clear,
//   limit off, buffer size all ones.
// A stalled m_ready holds the result register; the back end then stops shifting and
//   the front end stops once the queue is full.
module msb_first_bit_field_packer #(
    parameter int MAX_FIELD_BITS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  mbfp_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output mbfp_pkg::out_item_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [mbfp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CW = $clog2(MAX_FIELD_BITS + 1);
    localparam int QW = CW + MAX_FIELD_BITS;

    mbfp_pkg::cfg_t cfg_reg;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    logic [QW-1:0]  q_wdata;
    logic [QW-1:0]  q_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.limit_enable <= 1'b0;
            cfg_reg.buffer_bytes <= mbfp_pkg::BUFFER_BYTES_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mbfp_pkg::REG_LIMIT_ENABLE: cfg_reg.limit_enable <= cfg_wdata[0];
                mbfp_pkg::REG_BUFFER_BYTES: cfg_reg.buffer_bytes <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mbfp_front #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS),
        .CW(CW)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .q_push(q_push),
        .q_full(q_full),
        .q_wdata(q_wdata)
    );

    mbfp_queue #(
        .WIDTH(QW)
    ) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(q_push),
        .wdata(q_wdata),
        .full(q_full),
        .pop(q_pop),
        .empty(q_empty),
        .rdata(q_rdata)
    );

    mbfp_back #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS),
        .CW(CW)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg(cfg_reg),
        .q_empty(q_empty),
        .q_rdata(q_rdata),
        .q_pop(q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

endmodule

/* rtl/mbfp_checker.sv */
// Port-level checker for msb_first_bit_field_packer, with its bind.
// Uses mbfp_pkg.
module mbfp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input mbfp_pkg::out_item_t              m_data,
    input logic                             cfg_wr_en,
    input logic                             cfg_index,
    input logic [mbfp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic        lim_reg;
    logic [31:0] buf_reg;
    logic [31:0] exp_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg     <= 1'b0;
            buf_reg     <= mbfp_pkg::BUFFER_BYTES_RESET;
            exp_off_reg <= 32'd0;
        end else begin
            if (cfg_wr_en && (cfg_index == mbfp_pkg::REG_LIMIT_ENABLE)) begin
                lim_reg <= cfg_wdata[0];
            end
            if (cfg_wr_en && (cfg_index == mbfp_pkg::REG_BUFFER_BYTES)) begin
                buf_reg <= cfg_wdata;
            end
            if (m_valid && m_ready && m_data.stored) begin
                exp_off_reg <= exp_off_reg + 32'd1;
            end
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.byte_offset == exp_off_reg)
        else $error("byte offset out of sequence");

    a_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.stored == !(lim_reg && (m_data.byte_offset >= buf_reg)))
        else $error("stored flag disagrees with capacity limit");

endmodule

bind msb_first_bit_field_packer mbfp_checker u_mbfp_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data(m_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
);

/* tb/testbench.sv */
// Self-checking testbench for msb_first_bit_field_packer.
// Predicts the byte stream of append and pad requests in step with the block
// and compares every result field. Depends on rtl/mbfp_pkg.sv and the RTL.
module testbench;

    localparam int FIELD_BITS_MAX = 64;
    localparam int STALL_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int REPORT_MAX     = 10;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    mbfp_pkg::in_item_t              s_data;
    logic                            m_valid;
    logic                            m_ready;
    mbfp_pkg::out_item_t             m_data;
    logic                            cfg_wr_en;
    logic                            cfg_index;
    logic [mbfp_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // predicted block state and registers
    logic [7:0]  pend_bits;
    int          pend_cnt;
    logic [31:0] write_pos;
    logic        lim_en;
    logic [31:0] buf_size;

    mbfp_pkg::out_item_t expected_bytes[$];
    int                  mismatches;
    int                  stall_cycles;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    msb_first_bit_field_packer #(
        .MAX_FIELD_BITS(FIELD_BITS_MAX)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void shift_in(input logic b, inout mbfp_pkg::out_item_t held,
                                     inout bit have_held);
        logic keep;
        pend_bits = {pend_bits[6:0], b};
        pend_cnt++;
        if (pend_cnt == 8) begin
            keep = !(lim_en && write_pos >= buf_size);
            if (have_held)
                expected_bytes.push_back(held);
            held.out_byte    = pend_bits;
            held.byte_offset = write_pos;
            held.stored      = keep;
            held.last        = 1'b0;
            have_held        = 1'b1;
            if (keep)
                write_pos = write_pos + 32'd1;
            pend_bits = 8'h00;
            pend_cnt  = 0;
        end
    endfunction

    function automatic void pack_request(input mbfp_pkg::in_item_t req);
        int                  nbits;
        mbfp_pkg::out_item_t held;
        bit                  have_held;
        have_held = 1'b0;
        held      = '0;
        if (req.kind == mbfp_pkg::KIND_APPEND) begin
            nbits = (req.bit_count > FIELD_BITS_MAX) ? FIELD_BITS_MAX : int'(req.bit_count);
            for (int i = nbits; i > 0; i--)
                shift_in(req.field_value[i-1], held, have_held);
        end else begin
            while (pend_cnt != 0)
                shift_in(1'b0, held, have_held);
        end
        if (have_held) begin
            held.last = 1'b1;
            expected_bytes.push_back(held);
        end
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input mbfp_pkg::in_item_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pack_request(req);
        @(negedge aclk);
    endtask

    task automatic send_append(input logic [63:0] value, input logic [6:0] nbits);
        mbfp_pkg::in_item_t req;
        req.kind        = mbfp_pkg::KIND_APPEND;
        req.field_value = value;
        req.bit_count   = nbits;
        send_request(req);
    endtask

    task automatic send_pad();
        mbfp_pkg::in_item_t req;
        req.kind        = mbfp_pkg::KIND_PAD;
        req.field_value = {$urandom, $urandom};
        req.bit_count   = 7'($urandom);
        send_request(req);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_bytes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx,
                             input logic [mbfp_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == mbfp_pkg::REG_LIMIT_ENABLE)
            lim_en = value[0];
        else
            buf_size = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    task automatic test_field_extremes();
        send_append(64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
        send_append(64'h0000_0000_0000_0000, 7'd64);
        send_append(64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
        send_append(64'h0000_0000_0000_0001, 7'd1);
        send_pad();
        send_pad();
        send_append(64'hFFFF_FFFF_FFFF_FF5A, 7'd7);
        send_append(64'hFFFF_FFFF_FFFF_FFA5, 7'd8);
        send_append(64'h8123_4567_89AB_CDEF, 7'd127);
        send_append(64'hDEAD_BEEF_0BAD_F00D, 7'd65);
        send_append(64'h0000_0000_0000_0003, 7'd3);
        send_append(64'h0000_0000_0000_0000, 7'd0);
        send_pad();
        send_append(64'h5555_5555_5555_5555, 7'd13);
        send_append(64'hAAAA_AAAA_AAAA_AAAA, 7'd64);
        send_pad();
        wait_idle();
    endtask

    task automatic test_capacity_limit();
        write_reg(mbfp_pkg::REG_LIMIT_ENABLE, 32'd1);
        write_reg(mbfp_pkg::REG_BUFFER_BYTES, write_pos + 32'd6);
        for (int i = 0; i < 5; i++)
            send_append({$urandom, $urandom}, 7'd16);
        send_append(64'h0000_0000_0000_0001, 7'd5);
        send_pad();
        wait_idle();
        // position already past the new size: everything dropped
        write_reg(mbfp_pkg::REG_BUFFER_BYTES, 32'd0);
        send_append({$urandom, $urandom}, 7'd64);
        send_append(64'h0000_0000_0000_0007, 7'd3);
        send_pad();
        wait_idle();
        write_reg(mbfp_pkg::REG_BUFFER_BYTES, 32'hFFFF_FFFF);
        send_append({$urandom, $urandom}, 7'd40);
        wait_idle();
        write_reg(mbfp_pkg::REG_LIMIT_ENABLE, 32'd0);
        write_reg(mbfp_pkg::REG_BUFFER_BYTES, 32'd0);
        send_append({$urandom, $urandom}, 7'd24);
        wait_idle();
    endtask

    task automatic test_random_stream(input int n_requests);
        mbfp_pkg::in_item_t req;
        for (int i = 0; i < n_requests; i++) begin
            req.field_value = {$urandom, $urandom};
            req.kind        = ($urandom_range(99) < 15) ? mbfp_pkg::KIND_PAD
                                                        : mbfp_pkg::KIND_APPEND;
            case ($urandom_range(9))
                0:       req.bit_count = 7'($urandom_range(127, 65));
                1:       req.bit_count = 7'd64;
                2, 3:    req.bit_count = 7'($urandom_range(64));
                default: req.bit_count = 7'($urandom_range(20));
            endcase
            send_request(req);
        end
        wait_idle();
    endtask

    task automatic random_config();
        write_reg(mbfp_pkg::REG_LIMIT_ENABLE, 32'($urandom_range(1)));
        if ($urandom_range(1))
            write_reg(mbfp_pkg::REG_BUFFER_BYTES, write_pos + 32'($urandom_range(40)));
        else
            write_reg(mbfp_pkg::REG_BUFFER_BYTES, $urandom);
    endtask

    task automatic test_idle_mixes();
        set_idling(35, 72);
        random_config();
        test_random_stream(75);
        set_idling(72, 35);
        random_config();
        test_random_stream(75);
        set_idling(0, 0);
        random_config();
        test_random_stream(75);
    endtask

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        mbfp_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: byte %h offset %0d stored %b last %b",
                             m_data.out_byte, m_data.byte_offset, m_data.stored,
                             m_data.last);
            end else begin
                want = expected_bytes.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                                 want.out_byte, want.byte_offset, want.stored, want.last,
                                 m_data.out_byte, m_data.byte_offset, m_data.stored,
                                 m_data.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL msb_first_bit_field_packer");
            $finish;
        end
    end

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = mbfp_pkg::REG_LIMIT_ENABLE;
        cfg_wdata = '0;
        pend_bits = 8'h00;
        pend_cnt  = 0;
        write_pos = 32'd0;
        lim_en    = 1'b0;
        buf_size  = mbfp_pkg::BUFFER_BYTES_RESET;
        mismatches   = 0;
        stall_cycles = 0;
        set_idling(35, 72);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_field_extremes();
        test_capacity_limit();
        test_idle_mixes();

        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("PASS msb_first_bit_field_packer");
        else
            $display("FAIL msb_first_bit_field_packer");
        $finish;
    end

endmodule
